@@ rtl/lpht_pkg.sv @@
// package for the linear probing hash table
// word types, command and status codes, sequencer states; no dependencies
package lpht_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_LOOKUP  = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_DISP    = 3'd4,
        CMD_COMPACT = 3'd5,
        CMD_NOP6    = 3'd6,
        CMD_NOP7    = 3'd7
    } t_command;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  home_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_index;
        logic [31:0] found_key;
        logic [31:0] found_value;
        logic [15:0] displacement_total;
        logic [8:0]  entries_held;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DISP_RD,
        S_DISP_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_CMP_SRD,
        S_CMP_SCHK,
        S_DONE
    } t_state;

endpackage

@@ rtl/linear_probe_hash_table.sv @@
// linear probing hash table, top level with slot memory and sequencer
// depends on lpht_pkg
//
// One command at a time. A word is taken when idle, no result is waiting and
// no capacity write is offered. The result sits in an output register until
// it is taken. Clear and any capacity write sweep all TABLE_DEPTH occupancy
// bits, one slot per cycle, and a clear answers once the sweep ends. Insert,
// lookup and remove walk the probe circle one slot at a time, each slot a
// memory read (S_PROBE_RD) and a compare (S_PROBE_CHK), over at most capacity
// slots. Displacement walks every slot below capacity the same way. Compact
// reads and checks each slot and, for every entry away from its home, probes
// from its home for a free slot to move it to, stopping at its own slot. An
// out-of-range home, a full table on insert and an unused command answer
// without any probe. After reset a clearing pass over all TABLE_DEPTH slots
// runs before the first word is taken.
module linear_probe_hash_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpht_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpht_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data
);
    import lpht_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    // slot memory: key, value, home in one word, occupancy in flops
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  home;
    } t_slot;

    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rd;
    logic [TABLE_DEPTH-1:0] r_occ;
    logic [TABLE_DEPTH-1:0] n_occ;

    t_state r_state, n_state;
    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_ptr;     // probe / sweep pointer
    logic [AW-1:0] r_spos;    // compact: current slot s
    logic [CW-1:0] r_n;       // steps taken
    logic [16:0]   r_acc;
    t_slot         r_sent;    // compact: entry at s
    t_in_word      r_cmd;
    t_out_word     r_out;
    t_out_word     n_out;
    logic          r_out_v;
    logic          r_ok;      // probe success flag

    // handshakes
    logic          in_acc;
    logic          cfg_acc;

    // memory control
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_slot         mem_wd;
    logic [AW-1:0] mem_ra;
    logic          occ_set, occ_clr;
    logic [AW-1:0] occ_sa, occ_ca;

    // shared wrap increment and compare
    logic [CW-1:0] ptr_inc;
    logic [AW-1:0] ptr_next;
    logic          cur_occ;
    logic [CW-1:0] home_ext;
    logic          home_oor;
    logic          in_oor;
    logic [CW-1:0] cfg_cap;
    logic [CW:0]   wrap_dist;
    logic [17:0]   acc_sum;

    assign ptr_inc  = {1'b0, r_ptr} + CW'(1);
    assign ptr_next = (ptr_inc >= r_cap) ? '0 : ptr_inc[AW-1:0];
    assign cur_occ  = r_occ[r_ptr];
    assign home_ext = CW'(r_cmd.home_index);
    assign home_oor = home_ext >= r_cap;
    assign in_oor   = {1'b0, i_in_word.home_index} >= r_cap;

    always_comb begin
        if (i_cfg_data == 9'd0) begin
            cfg_cap = CW'(1);
        end else if (i_cfg_data > CW'(TABLE_DEPTH)) begin
            cfg_cap = CW'(TABLE_DEPTH);
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    // wrapped distance of the entry at r_ptr from its home
    always_comb begin
        if ({1'b0, r_ptr} >= CW'(r_rd.home)) begin
            wrap_dist = (CW+1)'(r_ptr) - (CW+1)'(r_rd.home);
        end else begin
            wrap_dist = (CW+1)'(r_ptr) + (CW+1)'(r_cap) - (CW+1)'(r_rd.home);
        end
        acc_sum = 18'(r_acc) + 18'(wrap_dist);
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_out_v || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_state = S_CLEAR;
                end else if (in_acc) begin
                    unique case (t_command'(i_in_word.command))
                        CMD_CLEAR:   n_state = S_CLEAR;
                        CMD_INSERT:  n_state = (in_oor || r_count >= r_cap) ? S_DONE
                                                                            : S_PROBE_RD;
                        CMD_LOOKUP,
                        CMD_REMOVE:  n_state = in_oor ? S_DONE : S_PROBE_RD;
                        CMD_DISP:    n_state = S_DISP_RD;
                        CMD_COMPACT: n_state = S_CMP_SRD;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if ({1'b0, r_ptr} == CW'(TABLE_DEPTH - 1)) begin
                    n_state = (r_cmd.command == CMD_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_PROBE_RD: n_state = S_PROBE_CHK;
            S_PROBE_CHK: begin
                priority if (r_cmd.command == CMD_INSERT) begin
                    if (!cur_occ || r_n + CW'(1) >= r_cap) n_state = S_DONE;
                    else n_state = S_PROBE_RD;
                end else begin
                    if ((cur_occ && r_rd.key == r_cmd.key) || r_n + CW'(1) >= r_cap)
                        n_state = S_DONE;
                    else n_state = S_PROBE_RD;
                end
            end
            S_DISP_RD: n_state = S_DISP_CHK;
            S_DISP_CHK: n_state = (r_n + CW'(1) >= r_cap) ? S_DONE : S_DISP_RD;
            S_CMP_SRD: n_state = S_CMP_SCHK;
            S_CMP_SCHK: begin
                if (!r_occ[r_spos] || CW'(r_rd.home) >= r_cap
                    || r_rd.home[AW-1:0] == r_spos) begin
                    n_state = ({1'b0, r_spos} + CW'(1) >= r_cap) ? S_DONE : S_CMP_SRD;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                if (!cur_occ || ptr_next == r_spos) begin
                    n_state = ({1'b0, r_spos} + CW'(1) >= r_cap) ? S_DONE : S_CMP_SRD;
                end else begin
                    n_state = S_CMP_CHK;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory and occupancy controls
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_ptr;
        mem_wd  = '{key: r_cmd.key, value: r_cmd.value, home: r_cmd.home_index};
        mem_ra  = r_ptr;
        occ_set = 1'b0;
        occ_clr = 1'b0;
        occ_sa  = r_ptr;
        occ_ca  = r_ptr;
        unique case (r_state)
            S_CLEAR: occ_clr = 1'b1;
            S_PROBE_CHK: begin
                if (r_cmd.command == CMD_INSERT && !cur_occ) begin
                    mem_we  = 1'b1;
                    occ_set = 1'b1;
                end
                if (r_cmd.command == CMD_REMOVE && cur_occ && r_rd.key == r_cmd.key) begin
                    occ_clr = 1'b1;
                end
            end
            S_CMP_SRD: mem_ra = r_spos;
            S_CMP_CHK: begin
                if (!cur_occ) begin
                    mem_we  = 1'b1;
                    mem_wd  = r_sent;
                    occ_set = 1'b1;
                    occ_clr = 1'b1;
                    occ_ca  = r_spos;
                end
            end
            default: ;
        endcase
    end

    // occupancy update
    always_comb begin
        n_occ = r_occ;
        if (occ_clr) n_occ[occ_ca] = 1'b0;
        if (occ_set) n_occ[occ_sa] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cap   <= CW'(TABLE_DEPTH);
            r_count <= '0;
            r_ptr   <= '0;
            r_spos  <= '0;
            r_n     <= '0;
            r_acc   <= '0;
            r_occ   <= '0;
            r_cmd   <= '{command: CMD_NOP7, default: '0};
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            unique case (r_state)
                S_IDLE: begin
                    r_n    <= '0;
                    r_acc  <= '0;
                    r_spos <= '0;
                    if (cfg_acc) begin
                        r_cap   <= cfg_cap;
                        r_count <= '0;
                        r_cmd.command <= CMD_NOP7;
                        r_ptr   <= '0;
                    end else if (in_acc) begin
                        r_cmd <= i_in_word;
                        if (i_in_word.command == CMD_CLEAR
                            || i_in_word.command == CMD_DISP) begin
                            r_ptr <= '0;
                        end else begin
                            r_ptr <= i_in_word.home_index[AW-1:0];
                        end
                    end else begin
                        r_ptr <= '0;
                    end
                end
                S_CLEAR: begin
                    r_ptr   <= r_ptr + AW'(1);
                    r_count <= '0;
                end
                S_PROBE_CHK: begin
                    r_n <= r_n + CW'(1);
                    if (n_state == S_PROBE_RD) r_ptr <= ptr_next;
                    if (occ_set) r_count <= r_count + CW'(1);
                    else if (occ_clr) r_count <= r_count - CW'(1);
                end
                S_DISP_CHK: begin
                    r_n   <= r_n + CW'(1);
                    r_ptr <= ptr_next;
                    if (cur_occ) r_acc <= (acc_sum > 18'd65535) ? 17'd65535 : acc_sum[16:0];
                end
                S_CMP_SCHK: begin
                    r_sent <= r_rd;
                    r_ptr  <= r_rd.home[AW-1:0];
                    if (n_state != S_CMP_RD) r_spos <= r_spos + AW'(1);
                end
                S_CMP_CHK: begin
                    r_ptr <= ptr_next;
                    if (n_state != S_CMP_CHK) r_spos <= r_spos + AW'(1);
                end
                default: ;
            endcase
        end
    end

    // result word contents
    always_comb begin
        n_out = '0;
        n_out.entries_held = r_count;
        unique case (t_command'(r_cmd.command))
            CMD_INSERT, CMD_LOOKUP, CMD_REMOVE: begin
                if (home_oor) begin
                    n_out.status = ST_RANGE;
                end else if (!r_ok) begin
                    n_out.status = (r_cmd.command == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
                end else begin
                    n_out.slot_index = r_ptr;
                    if (r_cmd.command == CMD_LOOKUP) begin
                        n_out.found_key   = r_rd.key;
                        n_out.found_value = r_rd.value;
                    end
                end
            end
            CMD_DISP: n_out.displacement_total = r_acc[15:0];
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_out   <= '0;
        end else if (r_state == S_DONE) begin
            r_out_v <= 1'b1;
            r_out   <= n_out;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    // probe success flag
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_ok <= 1'b0;
        end else if (r_state == S_PROBE_CHK) begin
            r_ok <= (occ_set || occ_clr
                     || (r_cmd.command == CMD_LOOKUP && cur_occ && r_rd.key == r_cmd.key));
        end
    end

endmodule
